/* hdl/cmm_pkg.sv */
package cmm_pkg;

    localparam int OP_W        = 2;
    localparam int IDX_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int CHUNK_IDX_W = 8;
    localparam int DIM_W       = 5;
    localparam int CHUNK_W     = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int START_W     = CHUNK_IDX_W + CHUNK_W;

    localparam logic [DIM_W-1:0]   ROWS_RESET  = 5'd16;
    localparam logic [DIM_W-1:0]   INNER_RESET = 5'd16;
    localparam logic [DIM_W-1:0]   COLS_RESET  = 5'd16;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A     = 2'd0,
        CFG_INNER_DIM  = 2'd1,
        CFG_COLS_B     = 2'd2,
        CFG_CHUNK_SIZE = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_ISSUE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd_en;
        logic             first;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] k;
        logic             load_out;
        logic             out_last;
    } cmm_cmd_t;

    typedef struct packed {
        logic pipe_empty;
        logic out_free;
    } cmm_status_t;

endpackage

/* hdl/cmm_ctrl.sv */
module cmm_ctrl #(
    parameter int MAX_DIM   = 16,
    parameter int MAX_CHUNK = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cmm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cmm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cmm_pkg::OP_W-1:0]        opcode,
    input  logic [cmm_pkg::CHUNK_IDX_W-1:0] chunk_index,
    output cmm_pkg::cmm_cmd_t               cmd,
    input  cmm_pkg::cmm_status_t            status
);
    import cmm_pkg::*;

    localparam int DIM_CAP = (MAX_DIM > 31) ? 31 : MAX_DIM;
    localparam int FLAT_W  = $clog2(DIM_CAP * DIM_CAP + 1);
    localparam int DIV_W   = (FLAT_W > DIM_W) ? FLAT_W : DIM_W;
    localparam logic [DIM_W-1:0]   DIM_MAX   = DIM_W'(DIM_CAP);
    localparam logic [CHUNK_W-1:0] CHUNK_MAX = CHUNK_W'(MAX_CHUNK);

    state_t               state_reg, state_next;
    logic [DIM_W-1:0]     rows_reg, inner_reg, cols_reg;
    logic [CHUNK_W-1:0]   chunk_reg;
    logic [START_W-1:0]   start_reg, start_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [CHUNK_W-1:0]   count_reg, count_next;
    logic [DIM_W-1:0]     row_reg, row_next;
    logic [DIM_W-1:0]     col_reg, col_next;
    logic [DIM_W-1:0]     k_reg, k_next;

    logic [DIM_W-1:0]     nr, ni, nc;
    logic [CHUNK_W-1:0]   cs;
    logic [2*DIM_W-1:0]   total_full;
    logic [START_W-1:0]   total_w;
    logic [START_W-1:0]   span_w;
    logic [START_W-1:0]   start_prod;
    logic                 in_fire;

    assign nr = (rows_reg == '0) ? DIM_W'(1) : ((rows_reg > DIM_MAX) ? DIM_MAX : rows_reg);
    assign ni = (inner_reg == '0) ? DIM_W'(1) : ((inner_reg > DIM_MAX) ? DIM_MAX : inner_reg);
    assign nc = (cols_reg == '0) ? DIM_W'(1) : ((cols_reg > DIM_MAX) ? DIM_MAX : cols_reg);
    assign cs = (chunk_reg == '0) ? CHUNK_W'(1)
              : ((chunk_reg > CHUNK_MAX) ? CHUNK_MAX : chunk_reg);

    assign total_full = nr * nc;
    assign total_w    = START_W'(total_full[FLAT_W-1:0]);
    assign span_w     = total_w - start_reg;
    assign start_prod = chunk_index * cs;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= ROWS_RESET;
            inner_reg <= INNER_RESET;
            cols_reg  <= COLS_RESET;
            chunk_reg <= CHUNK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS_A:     rows_reg  <= cfg_data[DIM_W-1:0];
                CFG_INNER_DIM:  inner_reg <= cfg_data[DIM_W-1:0];
                CFG_COLS_B:     cols_reg  <= cfg_data[DIM_W-1:0];
                CFG_CHUNK_SIZE: chunk_reg <= cfg_data[CHUNK_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= '0;
            rem_reg   <= '0;
            count_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            rem_reg   <= rem_next;
            count_reg <= count_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        start_next   = start_reg;
        rem_next     = rem_reg;
        count_next   = count_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        k_next       = k_reg;
        cmd          = '0;
        cmd.row      = row_reg;
        cmd.col      = col_reg;
        cmd.k        = k_reg;
        cmd.first    = (k_reg == '0);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (opcode == OP_LOAD_A)
                    begin
                        cmd.wr_a = 1'b1;
                    end
                    else if (opcode == OP_LOAD_B)
                    begin
                        cmd.wr_b = 1'b1;
                    end
                    else if (opcode == OP_COMPUTE)
                    begin
                        start_next = start_prod;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                if (start_reg >= total_w)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    count_next = (span_w < START_W'(cs)) ? CHUNK_W'(span_w) : cs;
                    rem_next   = DIV_W'(start_reg);
                    row_next   = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                // Repeated subtraction splits the first flat index into row and column.
                if (rem_reg >= DIV_W'(nc))
                begin
                    rem_next = rem_reg - DIV_W'(nc);
                    row_next = row_reg + DIM_W'(1);
                end
                else
                begin
                    col_next   = rem_reg[DIM_W-1:0];
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.rd_en = 1'b1;
                if (k_reg == ni - DIM_W'(1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    k_next = k_reg + DIM_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (status.pipe_empty && status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = (count_reg == CHUNK_W'(1));
                    if (count_reg == CHUNK_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg - CHUNK_W'(1);
                        k_next     = '0;
                        if (col_reg + DIM_W'(1) == nc)
                        begin
                            col_next = '0;
                            row_next = row_reg + DIM_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + DIM_W'(1);
                        end
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/cmm_datapath.sv */
module cmm_datapath #(
    parameter int MAX_DIM    = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [cmm_pkg::IDX_W-1:0]          row_index,
    input  logic [cmm_pkg::IDX_W-1:0]          col_index,
    input  logic signed [cmm_pkg::VALUE_W-1:0] entry_value,
    input  cmm_pkg::cmm_cmd_t                  cmd,
    output cmm_pkg::cmm_status_t               status,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cmm_pkg::IDX_W-1:0]          out_row,
    output logic [cmm_pkg::IDX_W-1:0]          out_col,
    output logic signed [cmm_pkg::VALUE_W-1:0] out_value,
    output logic                               last
);
    import cmm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int HALF  = (DATA_WIDTH + 1) / 2;
    localparam int HI_W  = DATA_WIDTH - HALF;

    logic [DATA_WIDTH-1:0] a_mem [DEPTH];
    logic [DATA_WIDTH-1:0] b_mem [DEPTH];

    logic                  load_ok;
    logic [AW-1:0]         wr_addr, rd_a_addr, rd_b_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    logic [DATA_WIDTH-1:0] a_q_reg, b_q_reg;
    logic                  v1_reg, first1_reg, v2_reg, first2_reg;
    logic [DATA_WIDTH-1:0] pp_ll_reg, pp_ll_next;
    logic [HI_W-1:0]       pp_cross_reg, pp_cross_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] prod;

    logic [HALF-1:0]       a_lo, b_lo;
    logic [HI_W-1:0]       a_hi, b_hi;
    logic [2*HALF-1:0]     ll_full;
    logic [HALF-1:0]       cross_full;

    logic                  out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]      out_row_reg, out_col_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic                  last_reg;

    assign load_ok   = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
    assign wr_addr   = AW'(32'(row_index) * MAX_DIM + 32'(col_index));
    assign wr_data   = DATA_WIDTH'(entry_value);
    assign rd_a_addr = AW'(32'(cmd.row) * MAX_DIM + 32'(cmd.k));
    assign rd_b_addr = AW'(32'(cmd.k) * MAX_DIM + 32'(cmd.col));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a && load_ok)
        begin
            a_mem[wr_addr] <= wr_data;
        end
        if (cmd.wr_b && load_ok)
        begin
            b_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            a_q_reg <= a_mem[rd_a_addr];
            b_q_reg <= b_mem[rd_b_addr];
        end
    end

    // The low half of the wrapped product needs only three half-width partial products.
    assign a_lo       = a_q_reg[HALF-1:0];
    assign b_lo       = b_q_reg[HALF-1:0];
    assign a_hi       = a_q_reg[DATA_WIDTH-1:HALF];
    assign b_hi       = b_q_reg[DATA_WIDTH-1:HALF];
    assign ll_full    = a_lo * b_lo;
    assign cross_full = a_lo * HALF'(b_hi) + HALF'(a_hi) * b_lo;
    assign pp_ll_next    = ll_full[DATA_WIDTH-1:0];
    assign pp_cross_next = cross_full[HI_W-1:0];

    assign prod     = pp_ll_reg + {pp_cross_reg, {HALF{1'b0}}};
    assign acc_next = first2_reg ? prod : (acc_reg + prod);

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            pp_ll_reg    <= pp_ll_next;
            pp_cross_reg <= pp_cross_next;
        end
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.load_out)
        begin
            out_row_reg   <= cmd.row[IDX_W-1:0];
            out_col_reg   <= cmd.col[IDX_W-1:0];
            out_value_reg <= VALUE_W'(acc_reg);
            last_reg      <= cmd.out_last;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            first1_reg    <= 1'b0;
            v2_reg        <= 1'b0;
            first2_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= cmd.rd_en;
            first1_reg    <= cmd.first;
            v2_reg        <= v1_reg;
            first2_reg    <= first1_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.pipe_empty = !v1_reg && !v2_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

endmodule

/* hdl/chunked_matrix_multiply.sv */
// Chunked integer matrix multiply. Load transfers write one entry of A or B. A compute
// transfer passes through a setup state, then a divide state that finds the row and
// column of the chunk's first element, then for each result issues one store read per
// multiply-accumulate step through the single read port of each matrix store, followed
// by a three-stage read, multiply and accumulate pipeline drain.
// A result waits in an output register, so the next result is computed while it is
// held. A new input transfer is taken once every result of a compute has been handed
// to the output register. Configuration writes are accepted at any time.
module chunked_matrix_multiply #(
    parameter int MAX_DIM    = 16,
    parameter int MAX_CHUNK  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cmm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cmm_pkg::OP_W-1:0]           opcode,
    input  logic [cmm_pkg::IDX_W-1:0]          row_index,
    input  logic [cmm_pkg::IDX_W-1:0]          col_index,
    input  logic signed [cmm_pkg::VALUE_W-1:0] entry_value,
    input  logic [cmm_pkg::CHUNK_IDX_W-1:0]    chunk_index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cmm_pkg::IDX_W-1:0]          out_row,
    output logic [cmm_pkg::IDX_W-1:0]          out_col,
    output logic signed [cmm_pkg::VALUE_W-1:0] out_value,
    output logic                               last
);
    import cmm_pkg::*;

    cmm_cmd_t    cmd;
    cmm_status_t status;

    cmm_ctrl #(
        .MAX_DIM   (MAX_DIM),
        .MAX_CHUNK (MAX_CHUNK)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .chunk_index (chunk_index),
        .cmd         (cmd),
        .status      (status)
    );

    cmm_datapath #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_index   (row_index),
        .col_index   (col_index),
        .entry_value (entry_value),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .last        (last)
    );

endmodule
